FILE: hdl/sph_pkg.sv
package sph_pkg;

  // Sizing of the stores and the fixed-point format
  localparam int PARTICLES = 4096;
  localparam int BINS      = 64;
  localparam int FRAC_BITS = 16;

  // Field widths fixed by the ports
  localparam int ID_W      = 12;
  localparam int COORD_W   = 32;
  localparam int SLAB_W    = 8;
  localparam int H_W       = 5;
  localparam int CNT_W     = 13;
  localparam int DIST_W    = 12;
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 2;

  // Derived widths
  localparam int PART_AW   = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int BIN_W     = $clog2(BINS);
  localparam int PRAM_W    = 2 * COORD_W + SLAB_W + 1;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int D_W       = COORD_W + 3;
  localparam int DIV_W     = D_W - FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int Z_W       = FRAC_BITS + 26;
  localparam int PROD_W    = SLAB_W + 2 + H_W + 1;

  localparam logic [CNT_W-1:0]          CNT_MAX  = '1;
  localparam logic signed [SLAB_W-1:0]  SLAB_MAX = SLAB_W'(2 ** (SLAB_W - 1) - 1);
  localparam logic signed [SLAB_W-1:0]  SLAB_MIN = SLAB_W'(2 ** (SLAB_W - 1));
  localparam logic signed [DIST_W-1:0]  DIST_MAX = DIST_W'(2 ** (DIST_W - 1) - 1);
  localparam logic signed [DIST_W-1:0]  DIST_MIN = DIST_W'(2 ** (DIST_W - 1));

  // Register reset values
  localparam logic [COORD_W-1:0] Z_MID_RST     = '0;
  localparam logic [COORD_W-1:0] RADIUS_SQ_RST = COORD_W'(167772);
  localparam logic [H_W-1:0]     HEIGHT_RST    = H_W'(2);

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_EOF    = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_Z_MID       = 2'd0,
    CFG_RADIUS_SQ   = 2'd1,
    CFG_SLAB_HEIGHT = 2'd2
  } cfg_reg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic sq_calc;
    logic mark_escaped;
    logic bin_rd;
    logic bin_inc;
    logic div_init;
    logic div_step;
    logic load_wr;
    logic dump_rd;
    logic clear_bins;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic id_ok;
    logic has_slabs;
    logic was_escaped;
    logic too_far;
    logic in_win;
    logic dump_last;
  } stat_t;

endpackage

FILE: hdl/sph_ram.sv
module sph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/sph_ctrl.sv
module sph_ctrl import sph_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] req_type,
  input  stat_t      stat,
  output logic       busy,
  output cmd_t       cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_RD     = 8'b0000_0010,
    S_SQ     = 8'b0000_0100,
    S_INC    = 8'b0000_1000,
    S_LDPREP = 8'b0001_0000,
    S_DIV    = 8'b0010_0000,
    S_LDWR   = 8'b0100_0000,
    S_DUMP   = 8'b1000_0000
  } state_t;

  state_t               state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    cmd.accept   = start && (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (cmd.accept) begin
          case (req_type)
            REQ_LOAD: begin
              if (stat.id_ok) state_next = S_LDPREP;
            end
            REQ_SAMPLE: begin
              if (stat.id_ok) state_next = S_RD;
            end
            REQ_EOF: begin
              if (stat.has_slabs) state_next = S_DUMP;
              else cmd.clear_bins = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        // drop escaped particles straight away
        if (stat.was_escaped) begin
          state_next = S_IDLE;
        end else begin
          cmd.sq_calc = 1'b1;
          state_next  = S_SQ;
        end
      end
      S_SQ: begin
        state_next = S_IDLE;
        if (stat.too_far) begin
          cmd.mark_escaped = 1'b1;
        end else if (stat.in_win) begin
          cmd.bin_rd = 1'b1;
          state_next = S_INC;
        end
      end
      S_INC: begin
        cmd.bin_inc = 1'b1;
        state_next  = S_IDLE;
      end
      S_LDPREP: begin
        cmd.div_init = 1'b1;
        div_cnt_next = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == DIV_CNT_W'(DIV_W - 1)) begin
          state_next = S_LDWR;
        end else begin
          div_cnt_next = div_cnt + 1'b1;
        end
      end
      S_LDWR: begin
        cmd.load_wr = 1'b1;
        state_next  = S_IDLE;
      end
      S_DUMP: begin
        cmd.dump_rd = 1'b1;
        if (stat.dump_last) begin
          cmd.clear_bins = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/sph_datapath.sv
module sph_datapath import sph_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_W-1:0]        cfg_data,
  input  logic [ID_W-1:0]           particle_id,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic signed [COORD_W-1:0] pos_z,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  output logic                      result_strobe,
  output logic [IDX_W-1:0]          bin_index,
  output logic signed [DIST_W-1:0]  slab_distance,
  output logic [CNT_W-1:0]          bin_count,
  output logic                      last
);

  // Configuration
  logic signed [COORD_W-1:0] z_mid;
  logic [COORD_W-1:0]        radius_sq;
  logic [H_W-1:0]            slab_height;
  logic [H_W-1:0]            h;

  always_ff @(posedge clk) begin
    if (rst) begin
      z_mid       <= Z_MID_RST;
      radius_sq   <= RADIUS_SQ_RST;
      slab_height <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_Z_MID:       z_mid       <= cfg_data;
        CFG_RADIUS_SQ:   radius_sq   <= cfg_data;
        CFG_SLAB_HEIGHT: slab_height <= cfg_data[H_W-1:0];
        default: ;
      endcase
    end
  end

  // zero height counts as one
  assign h = (slab_height == '0) ? H_W'(1) : slab_height;

  // Request capture
  logic [PART_AW-1:0]        id_q;
  logic signed [COORD_W-1:0] px_q, py_q, pz_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      id_q <= PART_AW'(particle_id);
      px_q <= pos_x;
      py_q <= pos_y;
      pz_q <= pos_z;
    end
  end

  assign stat.id_ok = (32'(particle_id) < 32'(PARTICLES));

  // Per-particle store: {ref x, ref y, slab number, escaped}
  logic              pram_we;
  logic [PRAM_W-1:0] pram_wdata, pram_rdata;
  logic signed [SLAB_W-1:0] k_new;

  assign pram_we    = cmd.mark_escaped | cmd.load_wr;
  assign pram_wdata = cmd.load_wr ? {px_q, py_q, k_new, 1'b0}
                                  : {pram_rdata[PRAM_W-1:1], 1'b1};

  sph_ram #(.WIDTH(PRAM_W), .DEPTH(PARTICLES)) u_pram (
    .clk   (clk),
    .we    (pram_we),
    .waddr (id_q),
    .wdata (pram_wdata),
    .re    (cmd.accept),
    .raddr (PART_AW'(particle_id)),
    .rdata (pram_rdata)
  );

  logic signed [COORD_W-1:0] ref_x, ref_y;
  logic signed [SLAB_W-1:0]  ref_k;

  assign ref_x = pram_rdata[PRAM_W-1 -: COORD_W];
  assign ref_y = pram_rdata[SLAB_W+COORD_W:SLAB_W+1];
  assign ref_k = pram_rdata[SLAB_W:1];
  assign stat.was_escaped = pram_rdata[0];

  // Slab bounds
  logic signed [SLAB_W-1:0] least, greatest;

  // Sample: squares, window and bin
  logic signed [COORD_W:0]  dx, dy;
  logic [COORD_W-1:0]       ax, ay;
  logic [SQ_W-1:0]          sx_q, sy_q;
  logic signed [SLAB_W+H_W:0] kh;
  logic signed [Z_W-1:0]    centre, half_z, pz_z;
  logic                     in_win_n, in_win_q;
  logic signed [SLAB_W:0]   bdiff;
  logic [BIN_W-1:0]         bin_sel_n, bin_sel;

  always_comb begin
    dx = {px_q[COORD_W-1], px_q} - {ref_x[COORD_W-1], ref_x};
    dy = {py_q[COORD_W-1], py_q} - {ref_y[COORD_W-1], ref_y};
    ax = dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
    ay = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);

    kh     = ref_k * $signed({1'b0, h});
    centre = Z_W'(z_mid) + (Z_W'(kh) <<< FRAC_BITS);
    half_z = signed'(Z_W'(h) << (FRAC_BITS - 1));
    pz_z   = Z_W'(pz_q);
    in_win_n = (pz_z > centre - half_z) && (pz_z < centre + half_z);

    bdiff = {ref_k[SLAB_W-1], ref_k} - {least[SLAB_W-1], least};
    if (bdiff < 0) begin
      bin_sel_n = '0;
    end else if (bdiff > $signed((SLAB_W + 1)'(BINS - 1))) begin
      bin_sel_n = BIN_W'(BINS - 1);
    end else begin
      bin_sel_n = bdiff[BIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_calc) begin
      sx_q     <= ax * ax;
      sy_q     <= ay * ay;
      in_win_q <= in_win_n;
      bin_sel  <= bin_sel_n;
    end
  end

  logic [SQ_W:0] sq_sum, thr;

  assign sq_sum       = (SQ_W + 1)'(sx_q) + (SQ_W + 1)'(sy_q);
  assign thr          = (SQ_W + 1)'(radius_sq) << FRAC_BITS;
  assign stat.too_far = (sq_sum > thr);
  assign stat.in_win  = in_win_q;

  // Histogram store with a valid bit per bin
  logic [BINS-1:0]   bin_valid;
  logic              bvalid_q;
  logic [BIN_W-1:0]  dump_idx, dump_end;
  logic [CNT_W-1:0]  bram_rdata, bin_cur, bin_wdata;

  assign bin_cur   = bvalid_q ? bram_rdata : '0;
  assign bin_wdata = (bin_cur == CNT_MAX) ? bin_cur : bin_cur + 1'b1;

  sph_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_bram (
    .clk   (clk),
    .we    (cmd.bin_inc),
    .waddr (bin_sel),
    .wdata (bin_wdata),
    .re    (cmd.bin_rd | cmd.dump_rd),
    .raddr (cmd.dump_rd ? dump_idx : bin_sel),
    .rdata (bram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
    end else if (cmd.clear_bins) begin
      bin_valid <= '0;
    end else if (cmd.bin_inc) begin
      bin_valid[bin_sel] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bin_rd) begin
      bvalid_q <= bin_valid[bin_sel];
    end
  end

  // Load: k = ceil(ceil(d / 2^F) / h), one quotient bit a step
  logic signed [D_W-1:0]   d_full, d_round, d_ceil;
  logic signed [DIV_W-1:0] d_units;
  logic [DIV_W-1:0]        div_num_n, div_num;
  logic [H_W-1:0]          div_rem;
  logic [H_W:0]            div_shift, div_sub;
  logic                    div_ge, div_neg;

  always_comb begin
    d_full    = D_W'(pz_q) - D_W'(z_mid) - (D_W'(h) << (FRAC_BITS - 1));
    d_round   = d_full + D_W'((1 << FRAC_BITS) - 1);
    d_ceil    = d_round >>> FRAC_BITS;
    d_units   = d_ceil[DIV_W-1:0];
    div_num_n = d_units[DIV_W-1] ? DIV_W'(~d_units + 1'b1)
                                 : DIV_W'(d_units + DIV_W'(h) - 1'b1);
    div_shift = {div_rem, div_num[DIV_W-1]};
    div_sub   = div_shift - {1'b0, h};
    div_ge    = (div_shift >= {1'b0, h});
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_num <= div_num_n;
      div_rem <= '0;
      div_neg <= d_units[DIV_W-1];
    end else if (cmd.div_step) begin
      div_num <= {div_num[DIV_W-2:0], div_ge};
      div_rem <= div_ge ? div_sub[H_W-1:0] : div_shift[H_W-1:0];
    end
  end

  // saturate the signed quotient to the slab number range
  always_comb begin
    if (div_neg) begin
      k_new = (div_num > DIV_W'(2 ** (SLAB_W - 1))) ? SLAB_MIN
                                                    : SLAB_W'(~div_num + 1'b1);
    end else begin
      k_new = (div_num > DIV_W'(2 ** (SLAB_W - 1) - 1)) ? SLAB_MAX
                                                         : SLAB_W'(div_num);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      least    <= SLAB_MAX;
      greatest <= SLAB_MIN;
    end else if (cmd.load_wr) begin
      if (k_new < least)    least    <= k_new;
      if (k_new > greatest) greatest <= k_new;
    end
  end

  // Dump
  logic signed [SLAB_W:0]   span;
  logic [BIN_W-1:0]         dump_end_n;
  logic signed [SLAB_W+1:0] dist_base;
  logic signed [PROD_W-1:0] dist_prod;
  logic signed [DIST_W-1:0] dist_sat;

  always_comb begin
    span = {greatest[SLAB_W-1], greatest} - {least[SLAB_W-1], least};
    if (span > $signed((SLAB_W + 1)'(BINS - 1))) begin
      dump_end_n = BIN_W'(BINS - 1);
    end else begin
      dump_end_n = span[BIN_W-1:0];
    end
    dist_base = {{2{least[SLAB_W-1]}}, least} + (SLAB_W + 2)'(dump_idx);
    dist_prod = dist_base * $signed({1'b0, h});
    if (dist_prod > PROD_W'(DIST_MAX)) begin
      dist_sat = DIST_MAX;
    end else if (dist_prod < PROD_W'(DIST_MIN)) begin
      dist_sat = DIST_MIN;
    end else begin
      dist_sat = dist_prod[DIST_W-1:0];
    end
  end

  assign stat.has_slabs = (greatest >= least);
  assign stat.dump_last = (dump_idx == dump_end);

  logic                     pend, p_last, p_valid;
  logic [BIN_W-1:0]         p_idx;
  logic signed [DIST_W-1:0] p_dist;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dump_idx <= '0;
      dump_end <= dump_end_n;
    end else if (cmd.dump_rd) begin
      dump_idx <= dump_idx + 1'b1;
    end
    if (cmd.dump_rd) begin
      p_idx   <= dump_idx;
      p_last  <= stat.dump_last;
      p_valid <= bin_valid[dump_idx];
      p_dist  <= dist_sat;
    end
    if (pend) begin
      bin_index     <= IDX_W'(p_idx);
      slab_distance <= p_dist;
      bin_count     <= p_valid ? bram_rdata : '0;
      last          <= p_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend          <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      pend          <= cmd.dump_rd;
      result_strobe <= pend;
    end
  end

endmodule

FILE: hdl/slab_persistence_histogram.sv
// Channel   Direction  Handshake                  Payload
// config    in         cfg_we                     cfg_index, cfg_data
// request   in         start, taken when !busy    req_type, particle_id, pos_x/y/z
// result    out        result_strobe, one cycle   bin_index, slab_distance,
//                                                 bin_count, last
//
// Sample: an already escaped particle ends after the particle store read; one that
// escapes now or lies outside its slab ends after the registered squares; one whose bin
// is counted also goes through the bin read-modify-write.
// Load: runs the one-bit-a-step slab number division (19 steps), then writes the store.
// End of frame: one bin store read a cycle; each result then passes the output
// register. rst is synchronous and clears control, configuration, slab bounds and bin
// valid bits; the stores need no clearing.
// The receiver cannot stall: every result is shown for exactly one cycle.
module slab_persistence_histogram import sph_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // configuration writes
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_W-1:0]        cfg_data,
  // request channel
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                req_type,
  input  logic [ID_W-1:0]           particle_id,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic signed [COORD_W-1:0] pos_z,
  // result channel
  output logic                      result_strobe,
  output logic [IDX_W-1:0]          bin_index,
  output logic signed [DIST_W-1:0]  slab_distance,
  output logic [CNT_W-1:0]          bin_count,
  output logic                      last
);

  // Controller drives commands; the datapath holds all stores and reports
  // the few conditions that steer the sequence.
  cmd_t  cmd;
  stat_t stat;

  sph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .busy     (busy),
    .cmd      (cmd)
  );

  // Datapath: per-particle store, histogram store with valid bits, the
  // divider for slab numbers and the result output register.
  sph_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .particle_id   (particle_id),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .cmd           (cmd),
    .stat          (stat),
    .result_strobe (result_strobe),
    .bin_index     (bin_index),
    .slab_distance (slab_distance),
    .bin_count     (bin_count),
    .last          (last)
  );

endmodule

FILE: bench/tb_slab_persistence_histogram.sv
`timescale 1ns / 1ps

module tb_slab_persistence_histogram;
  import sph_pkg::*;

  // Codes the package leaves unnamed: the spare request type and the spare register index
  localparam logic [1:0]           REQ_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Horizontal spreads for samples around the reference, from well inside to far outside
  localparam int unsigned SPREADS [5] = '{64, 16384, 65536, 1 << 20, 1 << 28};

  // Where a sample's z is placed relative to its own slab
  typedef enum logic [1:0] {
    Z_INSIDE,
    Z_EDGE,
    Z_ANY
  } z_pick_t;

  // One bin of an end-of-frame dump
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
    logic [CNT_W-1:0]  count;
    logic              last;
  } bin_result_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [COORD_W-1:0]        cfg_data;
  logic                      start;
  logic                      busy;
  logic [1:0]                req_type;
  logic [ID_W-1:0]           particle_id;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic                      result_strobe;
  logic [IDX_W-1:0]          bin_index;
  logic signed [DIST_W-1:0]  slab_distance;
  logic [CNT_W-1:0]          bin_count;
  logic                      last;

  slab_persistence_histogram u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .particle_id   (particle_id),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .result_strobe (result_strobe),
    .bin_index     (bin_index),
    .slab_distance (slab_distance),
    .bin_count     (bin_count),
    .last          (last)
  );

  // Histogram model: registers, per-particle stores, bins and slab bounds
  logic signed [COORD_W-1:0] hist_zmid;
  logic [COORD_W-1:0]        hist_radius_sq;
  logic [H_W-1:0]            hist_height;
  logic signed [COORD_W-1:0] part_ref_x [PARTICLES];
  logic signed [COORD_W-1:0] part_ref_y [PARTICLES];
  logic signed [SLAB_W-1:0]  part_slab [PARTICLES];
  logic                      part_escaped [PARTICLES];
  logic                      part_loaded [PARTICLES];
  logic [CNT_W-1:0]          hist_bins [BINS];
  logic signed [SLAB_W-1:0]  least_k;
  logic signed [SLAB_W-1:0]  greatest_k;

  // Dump bins still to come from the block, oldest first
  bin_result_t pending_bins [$];
  // Particles that have been loaded at least once; samples only ever address these
  logic [ID_W-1:0] loaded_ids [$];

  int errors;
  bit idling_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (errors < 100) $display("%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Histogram predictor
  // ---------------------------------------------------------------------------

  // Slab thickness in whole units; zero counts as one
  function automatic longint slab_units();
    return (hist_height == '0) ? 64'sd1 : longint'(hist_height);
  endfunction

  function automatic longint slab_fix();
    return slab_units() << FRAC_BITS;
  endfunction

  function automatic longint half_slab();
    return slab_units() << (FRAC_BITS - 1);
  endfunction

  // z of slab k's centre plus an offset, wrapped to the coordinate width
  function automatic logic [COORD_W-1:0] slab_z(input longint k, input longint off);
    longint z;
    z = longint'(hist_zmid) + k * slab_fix() + off;
    return z[COORD_W-1:0];
  endfunction

  function automatic void predict_load(input logic [ID_W-1:0] id,
                                       input logic signed [COORD_W-1:0] px,
                                       input logic signed [COORD_W-1:0] py,
                                       input logic signed [COORD_W-1:0] pz);
    longint d;
    longint q;
    // ceiling of (z - z_mid - H/2) / H, then clip to the slab number range
    d = longint'(pz) - longint'(hist_zmid) - half_slab();
    q = d / slab_fix();
    if (d % slab_fix() > 0) q++;
    if (q > longint'(SLAB_MAX)) q = longint'(SLAB_MAX);
    if (q < longint'(SLAB_MIN)) q = longint'(SLAB_MIN);
    part_ref_x[id]   = px;
    part_ref_y[id]   = py;
    part_slab[id]    = q[SLAB_W-1:0];
    part_escaped[id] = 1'b0;
    if (q < longint'(least_k)) least_k = q[SLAB_W-1:0];
    if (q > longint'(greatest_k)) greatest_k = q[SLAB_W-1:0];
    if (!part_loaded[id]) begin
      part_loaded[id] = 1'b1;
      loaded_ids = {loaded_ids, id};
    end
  endfunction

  function automatic void predict_sample(input logic [ID_W-1:0] id,
                                         input logic signed [COORD_W-1:0] px,
                                         input logic signed [COORD_W-1:0] py,
                                         input logic signed [COORD_W-1:0] pz);
    longint dx;
    longint dy;
    longint k;
    longint centre;
    longint bin;
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] sum_sq;
    logic [63:0] limit;
    logic [64:0] wide;
    if (part_escaped[id]) return;
    dx = longint'(px) - longint'(part_ref_x[id]);
    dy = longint'(py) - longint'(part_ref_y[id]);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    // each square fits in 64 bits; only their sum can overflow, and then it pins high
    wide   = {1'b0, ax * ax} + {1'b0, ay * ay};
    sum_sq = wide[64] ? '1 : wide[63:0];
    limit  = 64'(hist_radius_sq) << FRAC_BITS;
    if (sum_sq > limit) begin
      part_escaped[id] = 1'b1;
      return;
    end
    k      = longint'(part_slab[id]);
    centre = longint'(hist_zmid) + k * slab_fix();
    // count only strictly inside the particle's own slab
    if (longint'(pz) > centre - half_slab() && longint'(pz) < centre + half_slab()) begin
      bin = k - longint'(least_k);
      if (bin < 0) bin = 0;
      if (bin > BINS - 1) bin = BINS - 1;
      if (hist_bins[bin] != CNT_MAX) hist_bins[bin]++;
    end
  endfunction

  function automatic void predict_dump();
    longint n;
    longint distance;
    int i;
    bin_result_t r;
    if (greatest_k >= least_k) begin
      n = longint'(greatest_k) - longint'(least_k) + 1;
      if (n > BINS) n = BINS;
      for (i = 0; i < n; i++) begin
        distance = (longint'(least_k) + i) * slab_units();
        if (distance > longint'(DIST_MAX)) distance = longint'(DIST_MAX);
        if (distance < longint'(DIST_MIN)) distance = longint'(DIST_MIN);
        r.idx      = IDX_W'(i);
        r.distance = distance[DIST_W-1:0];
        r.count    = hist_bins[i];
        r.last     = (i == n - 1);
        pending_bins = {pending_bins, r};
      end
    end
    foreach (hist_bins[b]) hist_bins[b] = '0;
  endfunction

  function automatic void predict_request(input logic [1:0] req, input logic [ID_W-1:0] id,
                                          input logic signed [COORD_W-1:0] px,
                                          input logic signed [COORD_W-1:0] py,
                                          input logic signed [COORD_W-1:0] pz);
    case (req)
      REQ_LOAD:   predict_load(id, px, py, pz);
      REQ_SAMPLE: predict_sample(id, px, py, pz);
      REQ_EOF:    predict_dump();
      default:    ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest pending bin
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bin_result_t want;
    if (!rst && result_strobe) begin
      if (pending_bins.size() == 0) begin
        report_mismatch($sformatf("unexpected result, bin_index %0d", bin_index));
      end else begin
        want = pending_bins.pop_front();
        check_field("bin_index", 32'(bin_index), 32'(want.idx));
        check_field("slab_distance", 32'(unsigned'(slab_distance)), 32'(want.distance));
        check_field("bin_count", 32'(bin_count), 32'(want.count));
        check_field("last", 32'(last), 32'(want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request and register drivers; all called at a falling edge
  // ---------------------------------------------------------------------------

  // Present one request, hold it until taken, then predict its effect.
  // start is left high on return; the next call or hold_requests decides it.
  task automatic send_request(input logic [1:0] req, input logic [ID_W-1:0] id,
                              input logic signed [COORD_W-1:0] px,
                              input logic signed [COORD_W-1:0] py,
                              input logic signed [COORD_W-1:0] pz);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start       <= 1'b1;
    req_type    <= req;
    particle_id <= id;
    pos_x       <= px;
    pos_y       <= py;
    pos_z       <= pz;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(req, id, px, py, pz);
    @(negedge clk);
  endtask

  task automatic hold_requests();
    start <= 1'b0;
    @(negedge clk);
  endtask

  // Stop sending and wait for every pending bin to arrive
  task automatic drain_results();
    int waited;
    waited = 0;
    hold_requests();
    while (pending_bins.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    if (pending_bins.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", pending_bins.size()));
      pending_bins.delete();
    end
  endtask

  // Bring the block fully idle: no bins pending, no request in flight, load division done
  task automatic settle();
    drain_results();
    while (busy) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_Z_MID:       hist_zmid      = value;
      CFG_RADIUS_SQ:   hist_radius_sq = value;
      CFG_SLAB_HEIGHT: hist_height    = value[H_W-1:0];
      default:         ;
    endcase
  endtask

  // Settle, then write all three registers; the height write carries junk upper bits
  task automatic configure(input logic [COORD_W-1:0] zmid, input logic [COORD_W-1:0] radius_sq,
                           input logic [H_W-1:0] height);
    settle();
    write_reg(CFG_Z_MID, zmid);
    write_reg(CFG_RADIUS_SQ, radius_sq);
    write_reg(CFG_SLAB_HEIGHT, ($urandom() & ~32'h1F) | 32'(height));
  endtask

  // Load a particle with random x/y and z somewhere in slab k
  task automatic load_particle(input logic [ID_W-1:0] id, input longint k);
    longint off;
    off = longint'($urandom_range(0, 2 * half_slab() - 1)) - (half_slab() - 1);
    send_request(REQ_LOAD, id, $urandom(), $urandom(), slab_z(k, off));
  endtask

  // Sample a loaded particle: x/y within spread of its reference, z placed as asked
  task automatic sample_particle(input logic [ID_W-1:0] id, input int unsigned spread,
                                 input z_pick_t zpick);
    longint hh;
    longint k;
    longint off;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    hh = half_slab();
    k  = longint'(part_slab[id]);
    x  = part_ref_x[id] + COORD_W'(longint'($urandom_range(0, 2 * spread)) - spread);
    y  = part_ref_y[id] + COORD_W'(longint'($urandom_range(0, 2 * spread)) - spread);
    case (zpick)
      Z_INSIDE: begin
        off = longint'($urandom_range(0, 2 * hh - 2)) - (hh - 1);
        z   = slab_z(k, off);
      end
      Z_EDGE: begin
        case ($urandom_range(0, 3))
          0:       off = hh;
          1:       off = -hh;
          2:       off = hh - 1;
          default: off = 1 - hh;
        endcase
        z = slab_z(k, off);
      end
      default: z = $urandom();
    endcase
    send_request(REQ_SAMPLE, id, x, y, z);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // A dump before any load gives nothing; the spare type and spare register do nothing
  task automatic test_dump_before_load();
    send_request(REQ_EOF, ID_W'($urandom()), $urandom(), $urandom(), $urandom());
    send_request(REQ_UNUSED, ID_W'($urandom()), $urandom(), $urandom(), $urandom());
    settle();
    write_reg(CFG_UNUSED, $urandom());
  endtask

  // Three slabs at height zero (taken as one); centre, edge and just-inside samples
  task automatic test_small_frame();
    configure('0, RADIUS_SQ_RST, '0);
    send_request(REQ_LOAD, '0, '0, '0, slab_z(0, 0));
    send_request(REQ_LOAD, '1, 32'h7FFF_FFFF, 32'h8000_0000, slab_z(2, half_slab()));
    send_request(REQ_LOAD, 12'd1, 32'h0001_0000, 32'hFFFF_0000, slab_z(1, 1 - half_slab()));
    send_request(REQ_SAMPLE, '0, '0, '0, slab_z(0, 0));
    // edges are outside the open window
    send_request(REQ_SAMPLE, '0, '0, '0, slab_z(0, half_slab()));
    send_request(REQ_SAMPLE, '0, '0, '0, slab_z(0, -half_slab()));
    send_request(REQ_SAMPLE, '1, 32'h7FFF_FFFF, 32'h8000_0000, slab_z(2, half_slab() - 1));
    send_request(REQ_SAMPLE, 12'd1, 32'h0001_0000, 32'hFFFF_0000, slab_z(1, 1 - half_slab()));
    send_request(REQ_EOF, '0, '0, '0, '0);
  endtask

  // Escape by distance, square-sum overflow, ignored escaped samples, revival by reload
  task automatic test_escape_and_reload();
    send_request(REQ_LOAD, 12'd2, 32'h8000_0000, 32'h8000_0000, slab_z(1, 0));
    send_request(REQ_SAMPLE, 12'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, slab_z(1, 0));
    send_request(REQ_SAMPLE, 12'd2, 32'h8000_0000, 32'h8000_0000, slab_z(1, 0));
    send_request(REQ_LOAD, 12'd2, 32'h8000_0000, 32'h8000_0000, slab_z(1, 0));
    send_request(REQ_SAMPLE, 12'd2, 32'h8000_0000, 32'h8000_0000, slab_z(1, 0));
    send_request(REQ_SAMPLE, 12'd1, 32'h0001_0000 + 32'd200000, 32'hFFFF_0000, slab_z(1, 0));
    send_request(REQ_EOF, '0, '0, '0, '0);
  endtask

  // z at both ends saturates k; the dump widens to all bins and clamps the top bin
  task automatic test_extreme_slabs();
    send_request(REQ_LOAD, 12'd3, '0, '0, 32'h7FFF_FFFF);
    send_request(REQ_LOAD, 12'd4, '0, '0, 32'h8000_0000);
    send_request(REQ_SAMPLE, 12'd4, '0, '0, slab_z(longint'(part_slab[12'd4]), 0));
    send_request(REQ_EOF, '0, '0, '0, '0);
    // pause the request stream until the whole dump is out
    drain_results();
    send_request(REQ_SAMPLE, 12'd3, '0, '0, slab_z(longint'(part_slab[12'd3]), 0));
    send_request(REQ_EOF, '0, '0, '0, '0);
  endtask

  // Count one bin many times in a single frame, back to back
  task automatic test_bin_burst();
    configure('0, '1, H_W'(1));
    load_particle(12'd5, -100);
    idling_on = 1'b0;
    repeat (24)
      send_request(REQ_SAMPLE, 12'd5, part_ref_x[12'd5], part_ref_y[12'd5], slab_z(-100, 0));
    send_request(REQ_EOF, '0, '0, '0, '0);
    idling_on = 1'b1;
  endtask

  // Frames of loads and samples with random content under a series of register settings
  task automatic test_random_frames();
    int phase;
    int frame;
    int item;
    int pick;
    logic [ID_W-1:0] id;
    z_pick_t zpick;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: configure(COORD_W'($urandom_range(0, 1 << 24)) - (1 << 23), $urandom(),
                     H_W'($urandom_range(1, 16)));
        1: configure(32'h7FFF_FFFF, '0, H_W'(16));
        2: configure(32'h8000_0000, '1, H_W'(1));
        3: configure(COORD_W'($urandom_range(0, 1 << 24)) - (1 << 23), RADIUS_SQ_RST, '0);
        4: configure(COORD_W'($urandom_range(0, 1 << 24)) - (1 << 23),
                     COORD_W'($urandom_range(0, 1 << 24)), H_W'(31));
        default: begin
          configure($urandom(), $urandom(), H_W'($urandom_range(1, 16)));
          // run the closing phase back to back
          idling_on = 1'b0;
        end
      endcase
      for (frame = 0; frame < 3; frame++) begin
        for (item = 0; item < 14; item++) begin
          pick = $urandom_range(0, 99);
          if (pick < 15) begin
            // mostly reload known particles, sometimes a fresh id
            if ($urandom_range(0, 2) == 0)
              id = ID_W'($urandom());
            else
              id = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
            load_particle(id, longint'($urandom_range(0, 70)) - 128);
          end else if (pick < 85) begin
            id = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
            case ($urandom_range(0, 9))
              0:       zpick = Z_EDGE;
              1, 2:    zpick = Z_ANY;
              default: zpick = Z_INSIDE;
            endcase
            sample_particle(id, SPREADS[$urandom_range(0, 4)], zpick);
          end else if (pick < 92) begin
            // noise: wholly random positions
            if ($urandom_range(0, 1) == 0)
              send_request(REQ_LOAD, ID_W'($urandom()), $urandom(), $urandom(), $urandom());
            else
              send_request(REQ_SAMPLE, loaded_ids[$urandom_range(0, loaded_ids.size() - 1)],
                           $urandom(), $urandom(), $urandom());
          end else begin
            send_request(REQ_UNUSED, ID_W'($urandom()), $urandom(), $urandom(), $urandom());
          end
        end
        send_request(REQ_EOF, ID_W'($urandom()), $urandom(), $urandom(), $urandom());
      end
    end
  endtask

  initial begin
    // Drive every input known from time zero; hold reset before the tests start
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    start       = 1'b0;
    req_type    = '0;
    particle_id = '0;
    pos_x       = '0;
    pos_y       = '0;
    pos_z       = '0;
    errors      = 0;
    idling_on   = 1'b1;

    hist_zmid      = Z_MID_RST;
    hist_radius_sq = RADIUS_SQ_RST;
    hist_height    = HEIGHT_RST;
    least_k        = SLAB_MAX;
    greatest_k     = SLAB_MIN;
    foreach (hist_bins[b]) hist_bins[b] = '0;
    foreach (part_loaded[p]) begin
      part_loaded[p]  = 1'b0;
      part_escaped[p] = 1'b0;
      part_slab[p]    = '0;
      part_ref_x[p]   = '0;
      part_ref_y[p]   = '0;
    end

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_dump_before_load();
    test_small_frame();
    test_escape_and_reload();
    test_extreme_slabs();
    test_bin_burst();
    test_random_frames();

    settle();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: slab_persistence_histogram.f
hdl/sph_pkg.sv
hdl/sph_ram.sv
hdl/sph_ctrl.sv
hdl/sph_datapath.sv
hdl/slab_persistence_histogram.sv
bench/tb_slab_persistence_histogram.sv
